FILE: src/swq_pkg.sv
// ----------------------------------------------------------------------------
// swq_pkg
// shared types and constants of the sensor warning qualifier
// ----------------------------------------------------------------------------
package swq_pkg;

  localparam int unsigned DistW  = 16;
  localparam int unsigned TempW  = 16;
  localparam int unsigned HumidW = 8;
  localparam int unsigned CountW = 4;
  localparam int unsigned CodeW  = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // warning codes as reported on the result channel
  typedef enum logic [CodeW-1:0] {
    CODE_NORMAL     = 4'd0,
    CODE_DIST       = 4'd1,
    CODE_TEMP       = 4'd2,
    CODE_HUMID      = 4'd3,
    CODE_DIST_TEMP  = 4'd4,
    CODE_DIST_HUMID = 4'd5,
    CODE_TEMP_HUMID = 4'd6,
    CODE_ALL        = 4'd7,
    CODE_ERROR      = 4'd8
  } swq_code_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_DIST_THRESH  = 3'd0,
    REG_TEMP_THRESH  = 3'd1,
    REG_HUMID_THRESH = 3'd2,
    REG_REPEAT_LIMIT = 3'd3,
    REG_DIST_INVALID = 3'd4,
    REG_TEMP_INVALID = 3'd5,
    REG_HUMID_INVALID = 3'd6
  } swq_reg_e;

  typedef struct packed {
    logic        [DistW-1:0]  distance_threshold;
    logic signed [TempW-1:0]  temp_threshold;
    logic        [HumidW-1:0] humid_threshold;
    logic        [CountW-1:0] repeat_limit;
    logic        [DistW-1:0]  distance_invalid;
    logic signed [TempW-1:0]  temp_invalid;
    logic        [HumidW-1:0] humid_invalid;
  } swq_cfg_t;

  typedef struct packed {
    logic                     sample_missing;
    logic        [DistW-1:0]  distance;
    logic signed [TempW-1:0]  temperature;
    logic        [HumidW-1:0] humidity;
  } swq_sample_t;

endpackage

FILE: src/swq_if.sv
// ----------------------------------------------------------------------------
// swq interfaces
// sample, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface swq_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 sample_missing;
  logic        [swq_pkg::DistW-1:0]     distance;
  logic signed [swq_pkg::TempW-1:0]     temperature;
  logic        [swq_pkg::HumidW-1:0]    humidity;

  modport source (output valid, sample_missing, distance, temperature, humidity,
                  input ready);
  modport sink (input valid, sample_missing, distance, temperature, humidity,
                output ready);
endinterface

interface swq_code_if;
  logic                         valid;
  logic                         ready;
  logic [swq_pkg::CodeW-1:0]    alert_code;

  modport source (output valid, alert_code, input ready);
  modport sink (input valid, alert_code, output ready);
endinterface

interface swq_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [swq_pkg::CfgIdxW-1:0]    index;
  logic [swq_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/swq_cfg_regs.sv
// ----------------------------------------------------------------------------
// swq_cfg_regs
// configuration register file, written through the cfg channel
// ----------------------------------------------------------------------------
module swq_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [swq_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  logic [swq_pkg::CfgDataW-1:0] wr_data_i,
  output swq_pkg::swq_cfg_t cfg_o
);

  swq_pkg::swq_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (swq_pkg::swq_reg_e'(wr_idx_i))
        swq_pkg::REG_DIST_THRESH:   cfg_d.distance_threshold = wr_data_i;
        swq_pkg::REG_TEMP_THRESH:   cfg_d.temp_threshold     = $signed(wr_data_i);
        swq_pkg::REG_HUMID_THRESH:  cfg_d.humid_threshold    = wr_data_i[swq_pkg::HumidW-1:0];
        swq_pkg::REG_REPEAT_LIMIT:  cfg_d.repeat_limit       = wr_data_i[swq_pkg::CountW-1:0];
        swq_pkg::REG_DIST_INVALID:  cfg_d.distance_invalid   = wr_data_i;
        swq_pkg::REG_TEMP_INVALID:  cfg_d.temp_invalid       = $signed(wr_data_i);
        swq_pkg::REG_HUMID_INVALID: cfg_d.humid_invalid      = wr_data_i[swq_pkg::HumidW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.distance_threshold <= 16'd0;
      cfg_q.temp_threshold     <= 16'sh7FFF;
      cfg_q.humid_threshold    <= 8'd255;
      cfg_q.repeat_limit       <= 4'd3;
      cfg_q.distance_invalid   <= 16'hFFFF;
      cfg_q.temp_invalid       <= 16'sh8000;
      cfg_q.humid_invalid      <= 8'd255;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/swq_classify.sv
// ----------------------------------------------------------------------------
// swq_classify
// invalid-marker checks and threshold compares into a raw warning code
// ----------------------------------------------------------------------------
module swq_classify (
  input  swq_pkg::swq_sample_t sample_i,
  input  swq_pkg::swq_cfg_t    cfg_i,
  output swq_pkg::swq_code_e   cls_code_o
);

  logic err, dw, tw, hw;

  assign err = sample_i.sample_missing
            || (sample_i.distance    == cfg_i.distance_invalid)
            || (sample_i.temperature == cfg_i.temp_invalid)
            || (sample_i.humidity    == cfg_i.humid_invalid);
  assign dw = sample_i.distance <= cfg_i.distance_threshold;
  assign tw = sample_i.temperature >= cfg_i.temp_threshold;  // signed compare
  assign hw = sample_i.humidity >= cfg_i.humid_threshold;

  always_comb begin
    if (err) begin
      cls_code_o = swq_pkg::CODE_ERROR;
    end else begin
      case ({dw, tw, hw})
        3'b111:  cls_code_o = swq_pkg::CODE_ALL;
        3'b110:  cls_code_o = swq_pkg::CODE_DIST_TEMP;
        3'b101:  cls_code_o = swq_pkg::CODE_DIST_HUMID;
        3'b011:  cls_code_o = swq_pkg::CODE_TEMP_HUMID;
        3'b100:  cls_code_o = swq_pkg::CODE_DIST;
        3'b010:  cls_code_o = swq_pkg::CODE_TEMP;
        3'b001:  cls_code_o = swq_pkg::CODE_HUMID;
        default: cls_code_o = swq_pkg::CODE_NORMAL;
      endcase
    end
  end

endmodule

FILE: src/swq_qualify.sv
// ----------------------------------------------------------------------------
// swq_qualify
// run counter on repeated warning codes and the result code register
// ----------------------------------------------------------------------------
module swq_qualify (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  swq_pkg::swq_code_e            cls_code_i,
  input  logic [swq_pkg::CountW-1:0]    repeat_limit_i,
  output logic [swq_pkg::CodeW-1:0]     code_o
);

  swq_pkg::swq_code_e last_q, last_d;
  logic [swq_pkg::CountW-1:0] run_q, run_d;
  logic [swq_pkg::CodeW-1:0]  code_q, code_d;

  always_comb begin
    last_d = last_q;
    run_d  = run_q;
    case (cls_code_i)
      swq_pkg::CODE_ERROR: begin
        last_d = swq_pkg::CODE_ERROR;
        run_d  = repeat_limit_i;
        code_d = swq_pkg::CODE_ERROR;
      end
      swq_pkg::CODE_NORMAL: begin
        last_d = swq_pkg::CODE_NORMAL;
        run_d  = '0;
        code_d = swq_pkg::CODE_NORMAL;
      end
      default: begin
        if (cls_code_i == last_q) begin
          // saturate at the limit
          if (run_q < repeat_limit_i) begin
            run_d = run_q + 1'b1;
          end
        end else begin
          last_d = cls_code_i;
          run_d  = {{(swq_pkg::CountW-1){1'b0}}, 1'b1};
        end
        code_d = (run_d >= repeat_limit_i) ? cls_code_i : swq_pkg::CODE_NORMAL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= swq_pkg::CODE_NORMAL;
      run_q  <= '0;
    end else if (step_i) begin
      last_q <= last_d;
      run_q  <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      code_q <= code_d;
    end
  end

  assign code_o = code_q;

endmodule

FILE: src/sensor_warning_qualifier_core.sv
// ----------------------------------------------------------------------------
// sensor_warning_qualifier_core
// an accepted sample is held in the input reg and classified from it there;
// the run count and result reg then advance once the result reg is free or draining
// throughput: one sample per cycle while the result side takes each code
// on a result stall the input reg still takes one more item, then ready drops
// reset: async active low; config regs take their defaults, last code normal,
// run count zero, both pipeline stages empty
// ----------------------------------------------------------------------------
module sensor_warning_qualifier_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  swq_sample_if.sink    sample_i,
  swq_cfg_if.sink       cfg_i,
  swq_code_if.source    code_o
);

  // ---- configuration ----
  swq_pkg::swq_cfg_t cfg;

  assign cfg_i.ready = 1'b1;  // always ready; writes go straight into the config regs

  swq_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  // ---- input stage ----
  logic                 in_valid_q, in_valid_d;
  swq_pkg::swq_sample_t in_q;
  logic                 out_valid_q, out_valid_d;
  logic                 step;       // item moves from input reg to result reg
  logic                 in_accept;

  // result reg can take an item when empty or being drained this cycle
  assign step      = in_valid_q && (!out_valid_q || code_o.ready);
  assign sample_i.ready = !in_valid_q || step;
  assign in_accept = sample_i.valid && sample_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (code_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // sample payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q.sample_missing <= sample_i.sample_missing;
      in_q.distance       <= sample_i.distance;
      in_q.temperature    <= sample_i.temperature;
      in_q.humidity       <= sample_i.humidity;
    end
  end

  // ---- classify and qualify ----
  swq_pkg::swq_code_e cls_code;

  swq_classify u_classify (
    .sample_i   (in_q),
    .cfg_i      (cfg),
    .cls_code_o (cls_code)
  );

  swq_qualify u_qualify (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .cls_code_i     (cls_code),
    .repeat_limit_i (cfg.repeat_limit),
    .code_o         (code_o.alert_code)
  );

  assign code_o.valid = out_valid_q;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor warning qualifier testbench
// A short directed table opens the run: reset defaults, invalid markers,
// every warning combination, a repeat limit of zero and a limit lowered under
// a running count. Random phases follow, each with its own register setting
// and sender/receiver idling. Every item is predicted here and each result is
// checked in order against the expected warning codes.
// ----------------------------------------------------------------------------
module testbench;

  localparam int QUIET_LIMIT   = 1000;  // cycles without any accepted item
  localparam int SETTLE_CYCLES = 6;     // extra wait after the final drain
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 210;

  // one row of the directed table: a register write or a sample
  typedef struct {
    logic                           is_reg;
    swq_pkg::swq_reg_e              idx;
    logic [swq_pkg::CfgDataW-1:0]   data;
    swq_pkg::swq_sample_t           smp;
    logic                           given;   // expected code typed into the row
    swq_pkg::swq_code_e             code;
  } plan_row_t;

  logic clk;
  logic rst_n;

  swq_sample_if sample_ch ();
  swq_code_if   code_ch ();
  swq_cfg_if    cfg_ch ();

  sensor_warning_qualifier_core uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (sample_ch),
    .cfg_i    (cfg_ch),
    .code_o   (code_ch)
  );

  // idling controls, changed per phase
  int sender_idle_pct;
  int recv_stall_pct;

  int fail_count;
  int quiet_cycles;

  // travels with the sample item so the monitor sees it at the accept edge
  logic               code_given;
  swq_pkg::swq_code_e given_code;

  // predictor copy of registers and qualifier state
  swq_pkg::swq_cfg_t          model_cfg;
  swq_pkg::swq_code_e         model_last;
  logic [swq_pkg::CountW-1:0] model_run;

  // warning codes still owed by the block, oldest first
  swq_pkg::swq_code_e awaited_codes[$];

  plan_row_t plan[$];

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stalls at random, as the phase asks
  always @(posedge clk) begin
    code_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // combination of active warnings, or sensor error
  function automatic swq_pkg::swq_code_e classify_sample(swq_pkg::swq_sample_t s);
    logic dw, tw, hw;
    // an invalid marker wins even when the value also lies in a warning range
    if (s.sample_missing || s.distance == model_cfg.distance_invalid ||
        s.temperature == model_cfg.temp_invalid ||
        s.humidity == model_cfg.humid_invalid)
      return swq_pkg::CODE_ERROR;
    dw = (s.distance <= model_cfg.distance_threshold);
    tw = (s.temperature >= model_cfg.temp_threshold);  // signed compare
    hw = (s.humidity >= model_cfg.humid_threshold);
    case ({dw, tw, hw})
      3'b111:  return swq_pkg::CODE_ALL;
      3'b110:  return swq_pkg::CODE_DIST_TEMP;
      3'b101:  return swq_pkg::CODE_DIST_HUMID;
      3'b011:  return swq_pkg::CODE_TEMP_HUMID;
      3'b100:  return swq_pkg::CODE_DIST;
      3'b010:  return swq_pkg::CODE_TEMP;
      3'b001:  return swq_pkg::CODE_HUMID;
      default: return swq_pkg::CODE_NORMAL;
    endcase
  endfunction

  // reported code after run qualification, advances the model state
  function automatic swq_pkg::swq_code_e qualify_sample(swq_pkg::swq_sample_t s);
    swq_pkg::swq_code_e raw;
    raw = classify_sample(s);
    if (raw == swq_pkg::CODE_ERROR) begin
      // error sets last to error, so the next warning starts a fresh run
      model_last = swq_pkg::CODE_ERROR;
      model_run  = model_cfg.repeat_limit;
      return swq_pkg::CODE_ERROR;
    end
    if (raw == swq_pkg::CODE_NORMAL) begin
      model_last = swq_pkg::CODE_NORMAL;
      model_run  = '0;
      return swq_pkg::CODE_NORMAL;
    end
    if (raw == model_last) begin
      // saturate at the limit; a count above a lowered limit is kept
      if (model_run < model_cfg.repeat_limit) model_run = model_run + 1'b1;
    end else begin
      model_last = raw;
      model_run  = 4'd1;
    end
    return (model_run >= model_cfg.repeat_limit) ? raw : swq_pkg::CODE_NORMAL;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: register writes, sample predictions, result checks, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : monitor
    swq_pkg::swq_code_e   want;
    swq_pkg::swq_sample_t seen;
    logic                 moved;
    if (!rst_n) begin
      model_cfg = '{distance_threshold: 16'd0,     temp_threshold: 16'sd32767,
                    humid_threshold:    8'd255,    repeat_limit:   4'd3,
                    distance_invalid:   16'hFFFF,  temp_invalid:   16'h8000,
                    humid_invalid:      8'd255};
      model_last = swq_pkg::CODE_NORMAL;
      model_run  = '0;
      awaited_codes.delete();
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;

      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        case (swq_pkg::swq_reg_e'(cfg_ch.index))
          swq_pkg::REG_DIST_THRESH:
            model_cfg.distance_threshold = cfg_ch.data;
          swq_pkg::REG_TEMP_THRESH:
            model_cfg.temp_threshold     = cfg_ch.data;
          swq_pkg::REG_HUMID_THRESH:
            model_cfg.humid_threshold    = cfg_ch.data[swq_pkg::HumidW-1:0];
          swq_pkg::REG_REPEAT_LIMIT:
            model_cfg.repeat_limit       = cfg_ch.data[swq_pkg::CountW-1:0];
          swq_pkg::REG_DIST_INVALID:
            model_cfg.distance_invalid   = cfg_ch.data;
          swq_pkg::REG_TEMP_INVALID:
            model_cfg.temp_invalid       = cfg_ch.data;
          swq_pkg::REG_HUMID_INVALID:
            model_cfg.humid_invalid      = cfg_ch.data[swq_pkg::HumidW-1:0];
          default: ;
        endcase
      end

      // predict before checking so a result on the same edge still finds it
      if (sample_ch.valid && sample_ch.ready) begin
        moved = 1'b1;
        seen = {sample_ch.sample_missing, sample_ch.distance,
                sample_ch.temperature, sample_ch.humidity};
        want = qualify_sample(seen);
        if (code_given) want = given_code;
        awaited_codes.push_back(want);
      end

      if (code_ch.valid && code_ch.ready) begin
        moved = 1'b1;
        if (awaited_codes.size() == 0) begin
          $error("alert_code: expected none, got %0d", code_ch.alert_code);
          fail_count++;
        end else begin
          want = awaited_codes.pop_front();
          if (code_ch.alert_code !== want) begin
            $error("alert_code: expected %0d, got %0d", want, code_ch.alert_code);
            fail_count++;
          end
        end
      end

      // watchdog: a run of cycles with nothing accepted anywhere
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one sample item, with random idle cycles ahead of it
  task automatic send_sample(swq_pkg::swq_sample_t s, logic given,
                             swq_pkg::swq_code_e code);
    while ($urandom_range(99) < sender_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid          <= 1'b1;
    sample_ch.sample_missing <= s.sample_missing;
    sample_ch.distance       <= s.distance;
    sample_ch.temperature    <= s.temperature;
    sample_ch.humidity       <= s.humidity;
    code_given               <= given;
    given_code               <= code;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // register write; valid stays up so back-to-back writes need no gap
  task automatic apply_reg(swq_pkg::swq_reg_e idx, logic [swq_pkg::CfgDataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // hold the sender until every owed code has come back
  task automatic drain();
    sample_ch.valid <= 1'b0;
    do @(negedge clk); while (awaited_codes.size() != 0);
    @(posedge clk);
  endtask

  // all seven registers, junk in the unused upper bits of the narrow ones
  task automatic write_config(swq_pkg::swq_cfg_t c);
    drain();
    apply_reg(swq_pkg::REG_DIST_THRESH,   c.distance_threshold);
    apply_reg(swq_pkg::REG_TEMP_THRESH,   c.temp_threshold);
    apply_reg(swq_pkg::REG_HUMID_THRESH,  {8'($urandom), c.humid_threshold});
    apply_reg(swq_pkg::REG_REPEAT_LIMIT,  {12'($urandom), c.repeat_limit});
    apply_reg(swq_pkg::REG_DIST_INVALID,  c.distance_invalid);
    apply_reg(swq_pkg::REG_TEMP_INVALID,  c.temp_invalid);
    apply_reg(swq_pkg::REG_HUMID_INVALID, {8'($urandom), c.humid_invalid});
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus shaping
  // ---------------------------------------------------------------------------

  // sample whose raw code is the warning set in want (dist, temp, humid);
  // an absent warning that the thresholds make impossible falls back to the warning side
  function automatic swq_pkg::swq_sample_t shaped_sample(swq_pkg::swq_cfg_t c,
                                                         logic [2:0] want);
    swq_pkg::swq_sample_t s;
    int                   thr;
    s.sample_missing = 1'b0;
    thr = c.temp_threshold;
    for (int k = 0; k < 8; k++) begin
      if (want[2] || c.distance_threshold == 16'hFFFF)
        s.distance = 16'($urandom_range(c.distance_threshold, 0));
      else
        s.distance = 16'($urandom_range(16'hFFFF, c.distance_threshold + 1));
      if (want[1] || thr == -32768)
        s.temperature = 16'(thr + int'($urandom_range(32767 - thr, 0)));
      else
        s.temperature = 16'(-32768 + int'($urandom_range(thr + 32767, 0)));
      if (want[0] || c.humid_threshold == 0)
        s.humidity = 8'($urandom_range(255, c.humid_threshold));
      else
        s.humidity = 8'($urandom_range(c.humid_threshold - 1, 0));
      // steer clear of the invalid markers so runs are not cut short
      if (s.distance != c.distance_invalid && s.temperature != c.temp_invalid &&
          s.humidity != c.humid_invalid)
        break;
    end
    return s;
  endfunction

  // register setting of a random phase; the first two sit at the extremes
  function automatic swq_pkg::swq_cfg_t phase_config(int p);
    swq_pkg::swq_cfg_t c;
    case (p)
      0: c = '{distance_threshold: 16'hFFFF, temp_threshold: 16'h8000,
               humid_threshold:    8'd0,     repeat_limit:   4'd15,
               distance_invalid:   16'd1234, temp_invalid:   16'sd32767,
               humid_invalid:      8'd0};
      1: c = '{distance_threshold: 16'd0,    temp_threshold: 16'sd32767,
               humid_threshold:    8'd255,   repeat_limit:   4'd1,
               distance_invalid:   16'hFFFF, temp_invalid:   16'h8000,
               humid_invalid:      8'd255};
      default: begin
        c.distance_threshold = 16'($urandom);
        c.temp_threshold     = 16'($urandom);
        c.humid_threshold    = 8'($urandom);
        c.repeat_limit       = 4'($urandom_range(15, 1));
        c.distance_invalid   = 16'($urandom);
        c.temp_invalid       = 16'($urandom);
        c.humid_invalid      = 8'($urandom);
      end
    endcase
    return c;
  endfunction

  // mostly runs of one warning set, longer than the limit on occasion,
  // mixed with fully random noise and runs broken by error samples
  task automatic run_phase(swq_pkg::swq_cfg_t c, int n_items);
    swq_pkg::swq_sample_t s;
    logic [2:0]           want;
    int                   sent;
    int                   len;
    int                   pick;
    logic                 paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        want = 3'($urandom);
        len  = $urandom_range(c.repeat_limit + 3, 1);
        repeat (len) begin
          send_sample(shaped_sample(c, want), 1'b0, swq_pkg::CODE_NORMAL);
          sent++;
        end
      end else if (pick < 85) begin
        s.sample_missing = ($urandom_range(7) == 0);
        s.distance       = 16'($urandom);
        s.temperature    = 16'($urandom);
        s.humidity       = 8'($urandom);
        send_sample(s, 1'b0, swq_pkg::CODE_NORMAL);
        sent++;
      end else begin
        s = shaped_sample(c, 3'($urandom));
        case ($urandom_range(3))
          0:       s.sample_missing = 1'b1;
          1:       s.distance       = c.distance_invalid;
          2:       s.temperature    = c.temp_invalid;
          default: s.humidity       = c.humid_invalid;
        endcase
        send_sample(s, 1'b0, swq_pkg::CODE_NORMAL);
        sent++;
      end
      // sender backs off mid-phase until the block has caught up
      if (!paused && sent >= n_items / 2) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed table builders
  // ---------------------------------------------------------------------------
  function automatic void add_sample(int m, int d, int t, int h,
                                     logic given, swq_pkg::swq_code_e code);
    plan_row_t r;
    r.is_reg = 1'b0;
    r.idx    = swq_pkg::REG_DIST_THRESH;
    r.data   = '0;
    r.smp    = {m != 0, 16'(d), 16'(t), 8'(h)};
    r.given  = given;
    r.code   = code;
    plan.push_back(r);
  endfunction

  function automatic void add_reg(swq_pkg::swq_reg_e idx, int data);
    plan_row_t r;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.data   = 16'(data);
    r.smp    = '0;
    r.given  = 1'b0;
    r.code   = swq_pkg::CODE_NORMAL;
    plan.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic              cfg_open;
    swq_pkg::swq_cfg_t c;

    clk                      = 1'b0;
    rst_n                    = 1'b0;
    sample_ch.valid          = 1'b0;
    sample_ch.sample_missing = 1'b0;
    sample_ch.distance       = '0;
    sample_ch.temperature    = '0;
    sample_ch.humidity       = '0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.index             = swq_pkg::REG_DIST_THRESH;
    cfg_ch.data              = '0;
    code_given               = 1'b0;
    given_code               = swq_pkg::CODE_NORMAL;
    sender_idle_pct          = 0;
    recv_stall_pct           = 0;
    fail_count               = 0;
    cfg_open                 = 1'b0;

    // defaults after reset: distance warning only at zero, no humidity warning
    // reachable, temperature only at its maximum, limit three
    add_sample(0, 100,   20,     50,  1'b1, swq_pkg::CODE_NORMAL);
    // missing, fields at extremes
    add_sample(1, 0,     32767,  255, 1'b1, swq_pkg::CODE_ERROR);
    add_sample(0, 65535, 0,      0,   1'b1, swq_pkg::CODE_ERROR);  // distance marker
    add_sample(0, 1,     -32768, 0,   1'b1, swq_pkg::CODE_ERROR);  // temperature marker
    // humidity marker at threshold
    add_sample(0, 1,     0,      255, 1'b1, swq_pkg::CODE_ERROR);
    // dist+temp run after an error: reported from the third on, then held
    repeat (4) add_sample(0, 0, 32767, 254, 1'b0, swq_pkg::CODE_NORMAL);

    add_reg(swq_pkg::REG_DIST_THRESH,   500);
    add_reg(swq_pkg::REG_TEMP_THRESH,   -5);
    add_reg(swq_pkg::REG_HUMID_THRESH,  100);
    add_reg(swq_pkg::REG_REPEAT_LIMIT,  1);
    add_reg(swq_pkg::REG_DIST_INVALID,  200);   // marker inside the distance warning range
    add_reg(swq_pkg::REG_TEMP_INVALID,  10);
    add_reg(swq_pkg::REG_HUMID_INVALID, 0);
    add_sample(0, 200,   -6,     1,   1'b1, swq_pkg::CODE_ERROR);
    add_sample(0, 600,   -6,     1,   1'b1, swq_pkg::CODE_NORMAL);
    add_sample(0, 600,   -5,     1,   1'b1, swq_pkg::CODE_TEMP);  // limit one: at once
    add_sample(0, 600,   -6,     100, 1'b1, swq_pkg::CODE_HUMID);
    add_sample(0, 0,     32767,  255, 1'b1, swq_pkg::CODE_ALL);
    add_sample(0, 500,   -5,     99,  1'b0, swq_pkg::CODE_NORMAL);
    add_sample(0, 500,   -6,     100, 1'b0, swq_pkg::CODE_NORMAL);
    add_sample(0, 501,   -5,     100, 1'b0, swq_pkg::CODE_NORMAL);
    // old marker now valid
    add_sample(0, 65535, -32767, 1,   1'b1, swq_pkg::CODE_NORMAL);

    // limit zero reports every warning at once
    add_reg(swq_pkg::REG_REPEAT_LIMIT, 0);
    add_sample(0, 0, -6, 1, 1'b0, swq_pkg::CODE_NORMAL);

    // count a temperature run up to four, then lower the limit under it
    add_reg(swq_pkg::REG_REPEAT_LIMIT, 15);
    repeat (4) add_sample(0, 600, -5, 1, 1'b0, swq_pkg::CODE_NORMAL);
    add_reg(swq_pkg::REG_REPEAT_LIMIT, 2);
    add_sample(0, 600, -5, 1, 1'b0, swq_pkg::CODE_NORMAL);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, no idling
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!cfg_open) drain();
        apply_reg(plan[i].idx, plan[i].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_ch.valid <= 1'b0;
        cfg_open = 1'b0;
        send_sample(plan[i].smp, plan[i].given, plan[i].code);
      end
    end

    // random phases cycle through the idling patterns
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin sender_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      c = phase_config(p);
      write_config(c);
      run_phase(c, PHASE_ITEMS);
    end

    // wait out every owed code, then a little longer for strays
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_codes.size() != 0) begin
      $error("alert_code: %0d expected codes never arrived", awaited_codes.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/swq_pkg.sv
src/swq_if.sv
src/swq_cfg_regs.sv
src/swq_classify.sv
src/swq_qualify.sv
src/sensor_warning_qualifier_core.sv
tb/testbench.sv
